>>> design/w3ms_pkg.sv
// Shared constants for the 3x3 window mean, median and Sobel core.
// No dependencies.
`timescale 1ns / 1ps

package w3ms_pkg;

    localparam int SQ_W   = 21;   // width of R1^2 + R2^2
    localparam int ROOT_W = 11;   // width of its integer square root
    localparam int DIM_W  = 13;   // width of the held frame dimensions
    localparam int CFG_W  = 11;   // width of configuration data

    localparam logic [CFG_W-1:0] CFG_IDX_WIDTH  = 11'd0;
    localparam logic [CFG_W-1:0] CFG_IDX_HEIGHT = 11'd1;

    localparam logic [12:0] RECIP_NINE = 13'd7282;  // ceil(2^16 / 9)
    localparam int          MIN_DIM    = 3;
    localparam int          MAX_HEIGHT = 1024;

endpackage

>>> design/w3ms_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on w3ms_pkg for widths.
`timescale 1ns / 1ps

module w3ms_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [w3ms_pkg::SQ_W-1:0]     i_value,
    output logic                          o_done,
    output logic [w3ms_pkg::ROOT_W-1:0]   o_root
);

    localparam int VW = 2 * w3ms_pkg::ROOT_W;
    localparam int RW = w3ms_pkg::ROOT_W + 3;

    logic [VW-1:0]                 r_val;
    logic [RW-1:0]                 r_rem;
    logic [w3ms_pkg::ROOT_W-1:0]   r_root;
    logic [3:0]                    r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [RW-1:0]                 n_rem;
    logic [RW-1:0]                 trial;

    always_comb begin
        n_rem = {r_rem[RW-3:0], r_val[VW-1 -: 2]};
        trial = {1'b0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'(w3ms_pkg::ROOT_W);
                r_val  <= VW'(i_value);
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_val <= {r_val[VW-3:0], 2'b00};
                if (n_rem >= trial) begin
                    r_rem  <= n_rem - trial;
                    r_root <= {r_root[w3ms_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= n_rem;
                    r_root <= {r_root[w3ms_pkg::ROOT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> design/window3x3_mean_median_sobel_core.sv
// Top level: line stores, 3x3 window, mean, median and Sobel magnitude.
// Depends on w3ms_pkg and w3ms_isqrt.
`timescale 1ns / 1ps

// Usage:
// Pixels enter in raster order on the input channel (i_in_valid / o_in_ready),
// one transaction per pixel. Once row and column are both at least 2, each
// pixel yields one result on the output channel (o_out_valid / i_out_ready)
// for the window centre: mean, median, gradient magnitude, position and a
// frame_end flag on the last result of the frame. Border pixels yield none.
// A pixel that gives no result takes memory read, write-back and window shift;
// one that gives a result goes on through statistics, squaring, then the
// square root at one bit per cycle. The square root sets the rate.
// A finished result waits in the output register while the next pixel is
// taken; if the receiver still stalls when the next result is ready, the core
// holds that result and takes no pixel until the register frees.
// The line stores are not cleared; the window and counters reset to zero and
// the frame size to 640 x 480. A configuration write restarts the frame.
// Write configuration only while the core is idle.
module window3x3_mean_median_sobel_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [w3ms_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_pixel_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [9:0]                  o_center_row,
    output logic [9:0]                  o_center_col,
    output logic [7:0]                  o_box_mean,
    output logic [7:0]                  o_median_value,
    output logic [10:0]                 o_edge_magnitude,
    output logic                        o_frame_end
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DW = w3ms_pkg::DIM_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_CALC = 6'b000100,
        S_SQR  = 6'b001000,
        S_ROOT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state          r_state;
    logic [7:0]      mem_up  [MAX_WIDTH];
    logic [7:0]      mem_mid [MAX_WIDTH];
    logic [7:0]      r_up_rd;
    logic [7:0]      r_mid_rd;
    logic [7:0]      r_win [9];
    logic [7:0]      r_pix;
    logic [CW-1:0]   r_col;
    logic [9:0]      r_row;
    logic [CW-1:0]   r_col_cur;
    logic [9:0]      r_row_cur;
    logic            r_has_res;
    logic            r_fend;
    logic [DW-1:0]   r_width;
    logic [DW-1:0]   r_height;

    logic [11:0]     r_sum;
    logic signed [11:0] r_r1;
    logic signed [11:0] r_r2;
    logic [7:0]      r_med;
    logic [7:0]      r_mean;
    logic [19:0]     r_sq1;
    logic [19:0]     r_sq2;
    logic            r_sq_go;

    logic            in_acc;
    logic            out_free;
    logic [DW-1:0]   cfg_clamped;
    logic [DW-1:0]   col_next;
    logic [DW-1:0]   row_next;
    logic [11:0]     sum_c;
    logic [10:0]     sx_a, sx_b, sy_a, sy_b;
    logic [7:0]      med_c;
    logic [3:0]      rank [9];
    logic [24:0]     mean_prod;
    logic            sq_done;
    logic [w3ms_pkg::ROOT_W-1:0] sq_root;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !o_out_valid || i_out_ready;

    always_comb begin
        cfg_clamped = DW'(i_cfg_data);
        if (cfg_clamped < DW'(w3ms_pkg::MIN_DIM)) cfg_clamped = DW'(w3ms_pkg::MIN_DIM);
        if (i_cfg_index == w3ms_pkg::CFG_IDX_WIDTH[0]) begin
            if (cfg_clamped > DW'(MAX_WIDTH)) cfg_clamped = DW'(MAX_WIDTH);
        end else begin
            if (cfg_clamped > DW'(w3ms_pkg::MAX_HEIGHT)) cfg_clamped = DW'(w3ms_pkg::MAX_HEIGHT);
        end
        col_next = DW'(r_col) + DW'(1);
        row_next = DW'(r_row) + DW'(1);
    end

    always_comb begin
        sum_c = '0;
        for (int i = 0; i < 9; i++) sum_c = sum_c + 12'(r_win[i]);
        sx_a = 11'(r_win[6]) + {2'b0, r_win[7], 1'b0} + 11'(r_win[8]);
        sx_b = 11'(r_win[0]) + {2'b0, r_win[1], 1'b0} + 11'(r_win[2]);
        sy_a = 11'(r_win[2]) + {2'b0, r_win[5], 1'b0} + 11'(r_win[8]);
        sy_b = 11'(r_win[0]) + {2'b0, r_win[3], 1'b0} + 11'(r_win[6]);
        med_c = '0;
        for (int i = 0; i < 9; i++) begin
            rank[i] = '0;
            for (int j = 0; j < 9; j++) begin
                if (j < i && r_win[j] <= r_win[i]) rank[i] = rank[i] + 4'd1;
                if (j > i && r_win[j] <  r_win[i]) rank[i] = rank[i] + 4'd1;
            end
            if (rank[i] == 4'd4) med_c = r_win[i];
        end
        mean_prod = 25'(r_sum) * 25'(w3ms_pkg::RECIP_NINE);
    end

    // Line stores: read on acceptance, write back in the following cycle (S_READ).
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_up_rd  <= mem_up[r_col];
            r_mid_rd <= mem_mid[r_col];
        end
        if (r_state == S_READ) begin
            mem_up[r_col_cur]  <= r_mid_rd;
            mem_mid[r_col_cur] <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_width     <= DW'(640);
            r_height    <= DW'(480);
            r_sq_go     <= 1'b0;
            o_out_valid <= 1'b0;
            for (int i = 0; i < 9; i++) r_win[i] <= '0;
        end else begin
            r_sq_go <= (r_state == S_SQR);
            if (r_state == S_OUT && out_free) o_out_valid <= 1'b1;
            else if (i_out_ready) o_out_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == w3ms_pkg::CFG_IDX_WIDTH[0]) r_width <= cfg_clamped;
                else r_height <= cfg_clamped;
                r_col <= '0;
                r_row <= '0;
            end else if (in_acc) begin
                if (col_next >= r_width) begin
                    r_col <= '0;
                    r_row <= (row_next >= r_height) ? '0 : 10'(row_next);
                end else begin
                    r_col <= CW'(col_next);
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pix     <= i_pixel_value;
                        r_col_cur <= r_col;
                        r_row_cur <= r_row;
                        r_has_res <= (r_row >= 10'd2) && (DW'(r_col) >= DW'(2));
                        r_fend    <= (row_next == r_height) && (col_next == r_width);
                        r_state   <= S_READ;
                    end
                end
                S_READ: begin
                    r_win[0] <= r_win[1]; r_win[1] <= r_win[2]; r_win[2] <= r_up_rd;
                    r_win[3] <= r_win[4]; r_win[4] <= r_win[5]; r_win[5] <= r_mid_rd;
                    r_win[6] <= r_win[7]; r_win[7] <= r_win[8]; r_win[8] <= r_pix;
                    r_state  <= r_has_res ? S_CALC : S_IDLE;
                end
                S_CALC: begin
                    r_sum   <= sum_c;
                    r_med   <= med_c;
                    r_r1    <= $signed({1'b0, sx_a}) - $signed({1'b0, sx_b});
                    r_r2    <= $signed({1'b0, sy_a}) - $signed({1'b0, sy_b});
                    r_state <= S_SQR;
                end
                S_SQR: begin
                    r_sq1   <= 20'($signed(24'(r_r1)) * $signed(24'(r_r1)));
                    r_sq2   <= 20'($signed(24'(r_r2)) * $signed(24'(r_r2)));
                    r_mean  <= mean_prod[23:16];
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (sq_done) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output payload: load when the result leaves the sequencer.
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            o_center_row     <= r_row_cur - 10'd1;
            o_center_col     <= 10'(r_col_cur - CW'(1));
            o_box_mean       <= r_mean;
            o_median_value   <= r_med;
            o_edge_magnitude <= sq_root;
            o_frame_end      <= r_fend;
        end
    end

    w3ms_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_go),
        .i_value (21'(r_sq1) + 21'(r_sq2)),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

endmodule
